@@ design/time_triggered_task_scheduler_macros.svh @@
// ----------------------------------------------------------------------------
// Time-triggered task scheduler assertion macros
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TIME_TRIGGERED_TASK_SCHEDULER_MACROS_SVH
`define TIME_TRIGGERED_TASK_SCHEDULER_MACROS_SVH

`ifndef SYNTH
`define TTTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TTTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TTTS_ASSERT_IMPL(lbl, ante, cons, msg)
`define TTTS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ design/ttts_pkg.sv @@
// ----------------------------------------------------------------------------
// ttts_pkg
// Types and constants shared by the time-triggered task scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ttts_pkg;

  localparam int MAX_TASKS  = 8;
  localparam int SLOT_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int SCAN_LIMIT = (MAX_TASKS < 8) ? MAX_TASKS : 8;
  localparam int CNT_W      = $clog2(SCAN_LIMIT + 1);
  localparam int IDX_W      = 3;
  localparam int PERIOD_W   = 16;
  localparam int DELAY_W    = 18;
  localparam int PEND_W     = 16;
  localparam int NTASK_W    = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [1:0] REQ_LOAD     = 2'd0;
  localparam logic [1:0] REQ_TICK     = 2'd1;
  localparam logic [1:0] REQ_DISPATCH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TASKS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HYBRID       = 1'b1;

  localparam logic signed [DELAY_W-1:0] DELAY_MIN = {1'b1, {(DELAY_W-1){1'b0}}};
  localparam logic [PEND_W-1:0]         PEND_MAX  = {PEND_W{1'b1}};

  typedef struct packed {
    logic [PERIOD_W-1:0]       period;
    logic signed [DELAY_W-1:0] delay;
    logic                      tick_ctx;
  } slot_t;

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
    logic             disp;
    logic             last;
  } push_t;

endpackage

@@ design/ttts_slot_ram.sv @@
// ----------------------------------------------------------------------------
// ttts_slot_ram
// Task slot memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttts_slot_ram (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ttts_pkg::SLOT_W-1:0] wr_addr,
  input  ttts_pkg::slot_t            wr_data,
  input  logic                       rd_en,
  input  logic [ttts_pkg::SLOT_W-1:0] rd_addr,
  output ttts_pkg::slot_t            rd_data
);

  ttts_pkg::slot_t mem [ttts_pkg::MAX_TASKS];
  ttts_pkg::slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/ttts_out_stage.sv @@
// ----------------------------------------------------------------------------
// ttts_out_stage
// Result output register between the slot scan and the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttts_out_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ttts_pkg::push_t            push,
  output logic                       can_push,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ttts_pkg::IDX_W-1:0] out_task_index,
  output logic                       out_from_dispatch,
  output logic                       out_last
);

  logic                       valid_r;
  logic [ttts_pkg::IDX_W-1:0] idx_r;
  logic                       disp_r;
  logic                       last_r;

  assign can_push = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push.vld) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld) begin
      idx_r  <= push.idx;
      disp_r <= push.disp;
      last_r <= push.last;
    end
  end

  assign out_valid         = valid_r;
  assign out_task_index    = idx_r;
  assign out_from_dispatch = disp_r;
  assign out_last          = last_r;

endmodule

@@ design/ttts_scan.sv @@
// ----------------------------------------------------------------------------
// ttts_scan
// Request sequencer: slot loads, pending tick count and read-modify-write
// scans of the slot memory for ticks and dispatches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "time_triggered_task_scheduler_macros.svh"

module ttts_scan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_req_type,
  input  logic [2:0]                    in_task_slot,
  input  logic [ttts_pkg::PERIOD_W-1:0] in_task_period,
  input  logic [15:0]                   in_task_offset,
  input  logic                          in_run_in_tick,
  input  logic [ttts_pkg::NTASK_W-1:0]  tasks_in_use,
  input  logic                          hybrid_enable,
  output ttts_pkg::push_t               push,
  input  logic                          can_push
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RD    = 4'b0010,
    S_WR    = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [ttts_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [ttts_pkg::PEND_W-1:0]     pend_r, pend_nxt;
  logic                            disp_r, disp_nxt;
  logic                            held_vld_r, held_vld_nxt;
  logic [ttts_pkg::IDX_W-1:0]      held_idx_r, held_idx_nxt;

  logic [ttts_pkg::CNT_W-1:0]      scan_n;
  logic [ttts_pkg::CNT_W-1:0]      cnt_inc;
  logic                            accept;
  logic                            slot_ok;

  logic                            wr_en;
  logic [ttts_pkg::SLOT_W-1:0]     wr_addr;
  ttts_pkg::slot_t                 wr_data;
  logic                            rd_en;
  ttts_pkg::slot_t                 rd_data;

  logic signed [ttts_pkg::DELAY_W-1:0] d_dec;
  logic signed [ttts_pkg::DELAY_W-1:0] d_keep;
  logic                            hit;
  logic                            tick_ctx_eff;

  ttts_slot_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (cnt_r[ttts_pkg::SLOT_W-1:0]),
    .rd_data (rd_data)
  );

  assign scan_n  = (tasks_in_use > ttts_pkg::NTASK_W'(ttts_pkg::SCAN_LIMIT)) ?
                   ttts_pkg::CNT_W'(ttts_pkg::SCAN_LIMIT) :
                   ttts_pkg::CNT_W'(tasks_in_use);
  assign cnt_inc = cnt_r + ttts_pkg::CNT_W'(1);
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign slot_ok  = {29'd0, in_task_slot} < 32'(ttts_pkg::MAX_TASKS);

  assign tick_ctx_eff = hybrid_enable && rd_data.tick_ctx;
  assign d_dec  = (rd_data.delay != ttts_pkg::DELAY_MIN) ?
                  rd_data.delay - ttts_pkg::DELAY_W'(1) : rd_data.delay;
  assign d_keep = disp_r ? rd_data.delay : d_dec;
  assign hit    = disp_r ? (!tick_ctx_eff && (d_keep[ttts_pkg::DELAY_W-1] || d_keep == '0))
                         : ( tick_ctx_eff && (d_keep[ttts_pkg::DELAY_W-1] || d_keep == '0));

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    pend_nxt     = pend_r;
    disp_nxt     = disp_r;
    held_vld_nxt = held_vld_r;
    held_idx_nxt = held_idx_r;
    wr_en        = 1'b0;
    wr_addr      = cnt_r[ttts_pkg::SLOT_W-1:0];
    wr_data      = '{period: rd_data.period, delay: d_keep, tick_ctx: rd_data.tick_ctx};
    rd_en        = 1'b0;
    push         = '{vld: 1'b0, idx: held_idx_r, disp: disp_r, last: 1'b0};
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          case (in_req_type)
            ttts_pkg::REQ_LOAD: begin
              wr_en   = slot_ok;
              wr_addr = ttts_pkg::SLOT_W'(in_task_slot);
              wr_data = '{period:   in_task_period,
                          delay:    ttts_pkg::DELAY_W'({2'b00, in_task_offset})
                                    + ttts_pkg::DELAY_W'(1),
                          tick_ctx: in_run_in_tick};
            end
            ttts_pkg::REQ_TICK: begin
              if (pend_r != ttts_pkg::PEND_MAX) begin
                pend_nxt = pend_r + ttts_pkg::PEND_W'(1);
              end
              disp_nxt = 1'b0;
              if (scan_n != '0) begin
                state_nxt = S_RD;
              end
            end
            ttts_pkg::REQ_DISPATCH: begin
              if (pend_r != '0) begin
                pend_nxt = '0;
                disp_nxt = 1'b1;
                if (scan_n != '0) begin
                  state_nxt = S_RD;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        if (!(hit && held_vld_r && !can_push)) begin
          wr_en = 1'b1;
          if (hit) begin
            wr_data.delay = ttts_pkg::DELAY_W'({2'b00, rd_data.period});
            push.vld      = held_vld_r;
            held_vld_nxt  = 1'b1;
            held_idx_nxt  = ttts_pkg::IDX_W'(cnt_r);
          end
          cnt_nxt = cnt_inc;
          if (cnt_inc == scan_n) begin
            state_nxt = (hit || held_vld_r) ? S_FLUSH : S_IDLE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_FLUSH: begin
        if (can_push) begin
          push.vld     = 1'b1;
          push.last    = 1'b1;
          held_vld_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      pend_r     <= '0;
      disp_r     <= 1'b0;
      held_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      pend_r     <= pend_nxt;
      disp_r     <= disp_nxt;
      held_vld_r <= held_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_idx_r <= held_idx_nxt;
  end

  `TTTS_ASSERT_IMPL(a_push_has_room, push.vld, can_push, "result pushed into a full output stage")
  `TTTS_ASSERT_IMPL(a_last_from_flush, push.vld && push.last, state_r == S_FLUSH && held_vld_r, "final result outside flush")
  `TTTS_ASSERT_IMPL(a_cnt_in_range, state_r == S_RD || state_r == S_WR, cnt_r < scan_n, "scan index beyond scanned slots")
  `TTTS_ASSERT_NEXT(a_dispatch_drains, accept && in_req_type == ttts_pkg::REQ_DISPATCH, pend_r == '0, "pending ticks not drained by dispatch")

endmodule

@@ design/time_triggered_task_scheduler.sv @@
// ----------------------------------------------------------------------------
// time_triggered_task_scheduler
// Time-triggered cooperative scheduler over a memory of task slots.
// ----------------------------------------------------------------------------
// A load request writes one slot. A tick or dispatch request walks the first
// min(tasks_in_use, 8) slots through the slot memory, reading each slot in
// S_RD and then modifying and writing it back in S_WR, which waits while a
// due slot finds the output register full. The final result is handed over
// in S_FLUSH when any slot is due, waiting while the result channel stalls.
// A dispatch with no pending ticks, a tick or dispatch with no slots to scan,
// and an unknown request leave the scheduler idle without a scan. Requests
// are taken one at a time; results leave through a one-entry output register.
`timescale 1ns / 1ps

module time_triggered_task_scheduler (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_req_type,
  input  logic [2:0]                      in_task_slot,
  input  logic [15:0]                     in_task_period,
  input  logic [15:0]                     in_task_offset,
  input  logic                            in_run_in_tick,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      out_task_index,
  output logic                            out_from_dispatch,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ttts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ttts_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [ttts_pkg::NTASK_W-1:0] tasks_in_use_r;
  logic                         hybrid_enable_r;
  ttts_pkg::push_t              push;
  logic                         can_push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tasks_in_use_r  <= '0;
      hybrid_enable_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ttts_pkg::CFG_TASKS_IN_USE: tasks_in_use_r  <= cfg_data;
        ttts_pkg::CFG_HYBRID:       hybrid_enable_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  ttts_scan u_scan (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_task_slot   (in_task_slot),
    .in_task_period (in_task_period),
    .in_task_offset (in_task_offset),
    .in_run_in_tick (in_run_in_tick),
    .tasks_in_use   (tasks_in_use_r),
    .hybrid_enable  (hybrid_enable_r),
    .push           (push),
    .can_push       (can_push)
  );

  ttts_out_stage u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .can_push          (can_push),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_task_index    (out_task_index),
    .out_from_dispatch (out_from_dispatch),
    .out_last          (out_last)
  );

endmodule

@@ tb/tb_time_triggered_task_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_time_triggered_task_scheduler
// Drives load, tick and dispatch requests into the task scheduler, predicts
// the due-slot reports from its own copy of the slot tables, the pending tick
// count and the two registers, and checks every report in order. Covers the
// table extremes, zero periods, unknown requests and several register
// settings, with random idling on both channels and a long result hold-off.
// ----------------------------------------------------------------------------
module tb_time_triggered_task_scheduler;
  import ttts_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int GAP_MAX          = 13;
  localparam int SETTLE_CYCLES    = 40;
  localparam int HOLD_CYCLES      = 400;
  localparam int STALL_LIMIT      = 3000;
  localparam int PHASES           = 6;
  localparam int ITEMS_PER_PHASE  = 65;
  localparam int BURST_TICKS      = 20;
  localparam int MISMATCH_SHOWN   = 10;
  localparam int DELAY_FLOOR      = -(2 ** (DELAY_W - 1));

  typedef struct packed {
    bit [IDX_W-1:0] task_index;
    bit             from_dispatch;
    bit             is_last;
  } slot_report_t;

  class slot_report_board;
    bit [PERIOD_W-1:0] period_tbl [MAX_TASKS];
    int                delay_tbl [MAX_TASKS];
    bit                tick_ctx_tbl [MAX_TASKS];
    int unsigned       pend_ticks;
    bit [NTASK_W-1:0]  tasks_in_use;
    bit                hybrid_on;
    slot_report_t      due_reports [$];
    int unsigned       mismatches;

    function new();
      hybrid_on = 1'b1;
    endfunction

    function void write_register(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
      if (idx == CFG_TASKS_IN_USE) begin
        tasks_in_use = data;
      end else if (idx == CFG_HYBRID) begin
        hybrid_on = data[0];
      end
    endfunction

    function void take_request(bit [1:0] req, bit [2:0] slot, bit [PERIOD_W-1:0] period,
                               bit [15:0] offset, bit run_tick);
      int           scan;
      int           i;
      bit           sched;
      slot_report_t fresh [$];
      slot_report_t rpt;
      scan = tasks_in_use;
      if (scan > MAX_TASKS) scan = MAX_TASKS;
      if (scan > SCAN_LIMIT) scan = SCAN_LIMIT;
      case (req)
        REQ_LOAD: begin
          if (slot < MAX_TASKS) begin
            period_tbl[slot]   = period;
            delay_tbl[slot]    = int'(offset) + 1;
            tick_ctx_tbl[slot] = run_tick;
          end
        end
        REQ_TICK: begin
          if (pend_ticks < PEND_MAX) pend_ticks++;
          for (i = 0; i < scan; i++) begin
            if (delay_tbl[i] > DELAY_FLOOR) delay_tbl[i]--;
            if (hybrid_on && tick_ctx_tbl[i] && delay_tbl[i] <= 0) begin
              delay_tbl[i] = int'(period_tbl[i]);
              rpt = '{task_index: IDX_W'(i), from_dispatch: 1'b0, is_last: 1'b0};
              fresh.push_back(rpt);
            end
          end
        end
        REQ_DISPATCH: begin
          if (pend_ticks > 0) begin
            pend_ticks = 0;
            for (i = 0; i < scan; i++) begin
              sched = !(hybrid_on && tick_ctx_tbl[i]);
              if (sched && delay_tbl[i] <= 0) begin
                delay_tbl[i] = int'(period_tbl[i]);
                rpt = '{task_index: IDX_W'(i), from_dispatch: 1'b1, is_last: 1'b0};
                fresh.push_back(rpt);
              end
            end
          end
        end
        default: begin
        end
      endcase
      if (fresh.size() > 0) fresh[fresh.size() - 1].is_last = 1'b1;
      foreach (fresh[k]) due_reports.push_back(fresh[k]);
    endfunction

    function void flag_mismatch(string what, slot_report_t want, slot_report_t seen);
      mismatches++;
      if (mismatches <= MISMATCH_SHOWN) begin
        $display("%0t: %s: expected slot %0d disp %0d last %0d, got slot %0d disp %0d last %0d",
                 $realtime, what, want.task_index, want.from_dispatch, want.is_last,
                 seen.task_index, seen.from_dispatch, seen.is_last);
      end
    endfunction

    function void match_report(bit [IDX_W-1:0] idx, bit disp, bit lst);
      slot_report_t seen;
      slot_report_t want;
      seen = '{task_index: idx, from_dispatch: disp, is_last: lst};
      if (due_reports.size() == 0) begin
        flag_mismatch("unexpected report", '0, seen);
      end else begin
        want = due_reports.pop_front();
        if (want.task_index != seen.task_index) flag_mismatch("task_index mismatch", want, seen);
        else if (want.from_dispatch != seen.from_dispatch)
          flag_mismatch("from_dispatch mismatch", want, seen);
        else if (want.is_last != seen.is_last) flag_mismatch("last mismatch", want, seen);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            in_req_type;
  logic [2:0]            in_task_slot;
  logic [15:0]           in_task_period;
  logic [15:0]           in_task_offset;
  logic                  in_run_in_tick;
  logic                  out_valid;
  logic                  out_stall;
  logic [2:0]            out_task_index;
  logic                  out_from_dispatch;
  logic                  out_last;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  slot_report_board board = new();
  bit               sender_calm;
  bit               sink_calm;
  bit               long_hold;

  time_triggered_task_scheduler dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_task_slot      (in_task_slot),
    .in_task_period    (in_task_period),
    .in_task_offset    (in_task_offset),
    .in_run_in_tick    (in_run_in_tick),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_task_index    (out_task_index),
    .out_from_dispatch (out_from_dispatch),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int sender_gap();
    if ($urandom_range(0, 19) == 0) sender_calm = !sender_calm;
    return sender_calm ? 0 : int'($urandom_range(0, GAP_MAX));
  endfunction

  function automatic int sink_gap();
    if ($urandom_range(0, 19) == 0) sink_calm = !sink_calm;
    return sink_calm ? 0 : int'($urandom_range(0, GAP_MAX));
  endfunction

  task automatic send_request(int gap, logic [1:0] req, logic [2:0] slot, logic [15:0] period,
                              logic [15:0] offset, logic run_tick);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_task_slot   <= slot;
    in_task_period <= period;
    in_task_offset <= offset;
    in_run_in_tick <= run_tick;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.take_request(req, slot, period, offset, run_tick);
  endtask

  task automatic send_command(logic [1:0] req, int gap);
    send_request(gap, req, 3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom),
                 1'($urandom_range(0, 1)));
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (board.due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    board.write_register(idx, data);
  endtask

  task automatic send_random_request(output bit counted);
    int          pick;
    logic [1:0]  req;
    logic [15:0] period;
    logic [15:0] offset;
    pick = $urandom_range(0, 99);
    if (pick < 25) req = REQ_LOAD;
    else if (pick < 65) req = REQ_TICK;
    else if (pick < 94) req = REQ_DISPATCH;
    else req = REQ_UNKNOWN;
    pick = $urandom_range(0, 9);
    if (pick < 7) period = 16'($urandom_range(1, 12));
    else if (pick == 7) period = 16'd0;
    else period = 16'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 7) offset = 16'($urandom_range(0, 10));
    else offset = 16'($urandom);
    send_request(sender_gap(), req, 3'($urandom_range(0, 7)), period, offset,
                 1'($urandom_range(0, 1)));
    counted = (req != REQ_UNKNOWN);
  endtask

  initial begin : result_sink
    int wait_cycles;
    out_stall <= 1'b1;
    wait (rst_n === 1'b1);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end
      wait_cycles = sink_gap();
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1 || out_stall !== 1'b0);
      board.match_report(out_task_index, out_from_dispatch, out_last);
    end
  end

  initial begin : progress_watchdog
    int idle_cycles;
    idle_cycles = 0;
    wait (rst_n === 1'b1);
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0) ||
          (cfg_valid === 1'b1 && cfg_ready === 1'b1)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int              phase;
    int              counted_items;
    bit              counted;
    logic [3:0]      phase_tasks [PHASES];
    logic            phase_hybrid [PHASES];
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_req_type    <= REQ_LOAD;
    in_task_slot   <= '0;
    in_task_period <= '0;
    in_task_offset <= '0;
    in_run_in_tick <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_index      <= CFG_TASKS_IN_USE;
    cfg_data       <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // dispatch with nothing pending, unknown request
    send_command(REQ_DISPATCH, 0);
    send_request(1, REQ_UNKNOWN, 3'd7, 16'hFFFF, 16'hFFFF, 1'b1);

    // load every slot before any scan reaches it
    send_request(0, REQ_LOAD, 3'd0, 16'd1, 16'd0, 1'b1);
    send_request(0, REQ_LOAD, 3'd1, 16'hFFFF, 16'hFFFF, 1'b0);
    send_request(2, REQ_LOAD, 3'd2, 16'd0, 16'd0, 1'b0);
    send_request(0, REQ_LOAD, 3'd3, 16'd2, 16'd1, 1'b0);
    send_request(5, REQ_LOAD, 3'd4, 16'd3, 16'd0, 1'b1);
    send_request(0, REQ_LOAD, 3'd5, 16'd5, 16'd2, 1'b0);
    send_request(0, REQ_LOAD, 3'd6, 16'd1, 16'd0, 1'b0);
    send_request(13, REQ_LOAD, 3'd7, 16'd4, 16'd3, 1'b1);

    write_register(CFG_TASKS_IN_USE, 4'd8);
    repeat (3) send_command(REQ_TICK, sender_gap());
    send_command(REQ_DISPATCH, sender_gap());
    send_command(REQ_TICK, sender_gap());
    send_command(REQ_DISPATCH, sender_gap());
    send_command(REQ_DISPATCH, sender_gap());

    write_register(CFG_HYBRID, 1'b0);
    send_command(REQ_TICK, 0);
    send_command(REQ_TICK, 0);
    send_command(REQ_DISPATCH, 0);

    // run one long-period slot through a burst of ticks
    write_register(CFG_TASKS_IN_USE, 4'd1);
    write_register(CFG_HYBRID, 1'b1);
    send_request(0, REQ_LOAD, 3'd0, 16'hFFFF, 16'd0, 1'b0);
    repeat (BURST_TICKS) send_request(0, REQ_TICK, 3'd0, 16'd0, 16'd0, 1'b0);
    send_command(REQ_DISPATCH, 0);
    send_command(REQ_TICK, 0);

    phase_tasks  = '{4'd0, 4'd8, 4'd15, 4'd3, 4'd8, 4'd8};
    phase_hybrid = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    phase_tasks[4]  = 4'($urandom_range(1, 15));
    phase_hybrid[4] = 1'($urandom_range(0, 1));
    for (phase = 0; phase < PHASES; phase++) begin
      write_register(CFG_TASKS_IN_USE, phase_tasks[phase]);
      write_register(CFG_HYBRID, phase_hybrid[phase]);
      if (phase == 1) long_hold = 1'b1;
      counted_items = 0;
      while (counted_items < ITEMS_PER_PHASE) begin
        send_random_request(counted);
        if (counted) counted_items++;
      end
    end

    in_valid <= 1'b0;
    while (board.due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.due_reports.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
